// ----- rtl/fqp_pkg.sv -----
// Package for the FASTQ record parser: field tags, marker characters,
// result structure and default counter limit. No dependencies.
package fqp_pkg;

    localparam longint unsigned FQP_MAX_LEN = 64'd65535;
    localparam int unsigned     SEQ_LEN_W   = 16;

    localparam logic [7:0] CH_AT      = 8'h40;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_CR      = 8'h0D;

    typedef enum logic [2:0] {
        TAG_SKIP = 3'd0,
        TAG_H1   = 3'd1,
        TAG_SEQ  = 3'd2,
        TAG_H2   = 3'd3,
        TAG_QUAL = 3'd4
    } fqp_tag_t;

    typedef struct packed {
        logic [7:0]           out_byte;
        fqp_tag_t             field_tag;
        logic                 record_done;
        logic                 stream_done;
        logic                 format_error;
        logic [SEQ_LEN_W-1:0] seq_length;
    } fqp_result_t;

endpackage

// ----- rtl/fqp_step.sv -----
// Parser state machine: parse state, saturating counters and error flag,
// plus the per-request result logic. Depends on fqp_pkg.
module fqp_step
    import fqp_pkg::*;
#(
    parameter longint unsigned MAX_LEN = FQP_MAX_LEN
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        fire,
    input  logic [7:0]  byte_value,
    input  logic        stream_end,
    output fqp_result_t result
);

    localparam int unsigned CNT_W = $clog2(MAX_LEN + 64'd1);
    localparam int unsigned LEN_W = (CNT_W > SEQ_LEN_W) ? CNT_W : SEQ_LEN_W;
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_LEN);
    localparam logic [LEN_W-1:0] SHOW_MAX = LEN_W'({SEQ_LEN_W{1'b1}});

    typedef enum logic [2:0] {
        ST_NEED_H1 = 3'd0,
        ST_IN_H1   = 3'd1,
        ST_IN_SEQ  = 3'd2,
        ST_IN_H2   = 3'd3,
        ST_IN_QUAL = 3'd4
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] seq_count_reg, seq_count_next;
    logic [CNT_W-1:0] qual_count_reg, qual_count_next;
    logic             error_reg, error_next;

    logic             is_end;
    logic             is_blank;
    logic [CNT_W-1:0] seq_shown_src;
    logic [LEN_W-1:0] seq_wide;
    logic [CNT_W:0]   qual_plus_one;
    logic             done;

    assign is_end   = stream_end || (byte_value == 8'd0) || byte_value[7];
    assign is_blank = (byte_value == CH_SPACE)
                   || ((byte_value >= CH_TAB) && (byte_value <= CH_CR));
    assign qual_plus_one = {1'b0, qual_count_reg} + {{CNT_W{1'b0}}, 1'b1};

    always_comb
    begin
        state_next         = state_reg;
        seq_count_next     = seq_count_reg;
        qual_count_next    = qual_count_reg;
        error_next         = error_reg;
        done               = 1'b0;
        result.out_byte    = 8'd0;
        result.field_tag   = TAG_SKIP;
        result.stream_done = 1'b0;
        seq_shown_src      = seq_count_reg;

        if (is_end)
        begin
            result.stream_done = 1'b1;
            state_next         = ST_NEED_H1;
            seq_count_next     = '0;
            qual_count_next    = '0;
            error_next         = 1'b0;
        end
        else
        begin
            unique case (state_reg)
                ST_IN_H1:
                begin
                    if (byte_value == CH_NEWLINE)
                        state_next = ST_IN_SEQ;
                    else
                    begin
                        result.field_tag = TAG_H1;
                        result.out_byte  = byte_value;
                    end
                end
                ST_IN_SEQ:
                begin
                    if (!is_blank)
                    begin
                        if (byte_value == CH_PLUS)
                            state_next = ST_IN_H2;
                        else
                        begin
                            result.field_tag = TAG_SEQ;
                            result.out_byte  = byte_value;
                            seq_count_next   = (seq_count_reg >= CNT_MAX) ?
                                               CNT_MAX : seq_count_reg + CNT_W'(1);
                        end
                    end
                end
                ST_IN_H2:
                begin
                    if (byte_value == CH_NEWLINE)
                        state_next = ST_IN_QUAL;
                    else
                    begin
                        result.field_tag = TAG_H2;
                        result.out_byte  = byte_value;
                    end
                end
                ST_IN_QUAL:
                begin
                    if (!is_blank)
                    begin
                        result.field_tag = TAG_QUAL;
                        result.out_byte  = byte_value;
                        done             = (qual_plus_one >= {1'b0, seq_count_reg});
                        qual_count_next  = (qual_count_reg >= CNT_MAX) ?
                                           CNT_MAX : qual_count_reg + CNT_W'(1);
                    end
                end
                default:
                begin
                    if (!is_blank)
                    begin
                        if (byte_value == CH_AT)
                            state_next = ST_IN_H1;
                        else
                            error_next = 1'b1;
                    end
                end
            endcase
            seq_shown_src = seq_count_next;
            if (done)
            begin
                state_next      = ST_NEED_H1;
                seq_count_next  = '0;
                qual_count_next = '0;
            end
        end

        seq_wide            = LEN_W'(seq_shown_src);
        result.record_done  = done;
        result.format_error = is_end ? error_reg : error_next;
        result.seq_length   = (seq_wide > SHOW_MAX) ? SHOW_MAX[SEQ_LEN_W-1:0]
                                                    : seq_wide[SEQ_LEN_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_NEED_H1;
            seq_count_reg  <= '0;
            qual_count_reg <= '0;
            error_reg      <= 1'b0;
        end
        else if (fire)
        begin
            state_reg      <= state_next;
            seq_count_reg  <= seq_count_next;
            qual_count_reg <= qual_count_next;
            error_reg      <= error_next;
        end
    end

endmodule

// ----- rtl/fastq_record_parser_top.sv -----
// Data path: input request to output request through the input reg and the result reg.
// Throughput: 1 byte per cycle while the receiver does not stall; the parser state updates once per request.
// Reset (rst_n, async low): parse state waits for '@', counters and error clear.
// Top level of the FASTQ record parser: input register, fqp_step, result
// register. Depends on fqp_pkg and fqp_step.
module fastq_record_parser_top
    import fqp_pkg::*;
#(
    parameter longint unsigned MAX_LEN = FQP_MAX_LEN
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [7:0]           byte_value,
    input  logic                 stream_end,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [7:0]           out_byte,
    output logic [2:0]           field_tag,
    output logic                 record_done,
    output logic                 stream_done,
    output logic                 format_error,
    output logic [SEQ_LEN_W-1:0] seq_length
);

    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        in_end_reg;
    logic        out_valid_reg;
    fqp_result_t out_reg;
    fqp_result_t step_result;
    logic        advance;
    logic        in_take;

    assign advance  = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && out_valid_reg && out_stall;
    assign in_take  = in_valid && !in_stall;

    fqp_step #(
        .MAX_LEN (MAX_LEN)
    ) u_step (
        .clk        (clk),
        .rst_n      (rst_n),
        .fire       (advance),
        .byte_value (in_byte_reg),
        .stream_end (in_end_reg),
        .result     (step_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_take)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_byte_reg <= byte_value;
            in_end_reg  <= stream_end;
        end
        if (advance)
            out_reg <= step_result;
    end

    assign out_valid    = out_valid_reg;
    assign out_byte     = out_reg.out_byte;
    assign field_tag    = out_reg.field_tag;
    assign record_done  = out_reg.record_done;
    assign stream_done  = out_reg.stream_done;
    assign format_error = out_reg.format_error;
    assign seq_length   = out_reg.seq_length;

`ifndef SYNTHESIS
    a_done_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(record_done && stream_done))
        else $error("record_done and stream_done together");
    a_skip_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && field_tag == TAG_SKIP) |-> (out_byte == 8'd0))
        else $error("skipped byte not zeroed");
    a_done_qual: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && record_done) |-> (field_tag == TAG_QUAL))
        else $error("record closed on non-quality byte");
    a_end_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && in_end_reg) |=> (out_valid && stream_done))
        else $error("stream end not reported");
    a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (in_valid_reg && out_valid_reg))
        else $error("input stalled with free pipeline");
`endif

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 100ps
// Testbench for fastq_record_parser_top: directed rows, random FASTQ records and one
// gapless burst. Typed rows are checked against their own expected results, the rest
// against an in-bench parser predictor. Depends on fqp_pkg and the parser RTL.
module testbench;
    import fqp_pkg::*;

    localparam int IDLE_LIMIT = 2000;
    localparam int RAND_ITEMS = 1200;

    typedef enum logic [2:0] {
        PS_WAIT_AT = 3'd0,
        PS_HDR1    = 3'd1,
        PS_SEQ     = 3'd2,
        PS_HDR2    = 3'd3,
        PS_QUAL    = 3'd4
    } parse_state_t;

    typedef struct {
        logic [7:0]  b;
        logic        e;
        bit          typed;
        fqp_result_t res;
    } dir_row_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic [7:0]           byte_value = 8'h00;
    logic                 stream_end = 1'b0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [7:0]           out_byte;
    logic [2:0]           field_tag;
    logic                 record_done;
    logic                 stream_done;
    logic                 format_error;
    logic [SEQ_LEN_W-1:0] seq_length;

    // typed expectation travels with the request
    bit                   req_typed = 1'b0;
    fqp_result_t          req_res = '0;

    parse_state_t         ps;
    longint unsigned      seq_cnt;
    longint unsigned      qual_cnt;
    logic                 err_flag;

    fqp_result_t          parsed_bytes[$];
    fqp_result_t          got_res;
    fqp_result_t          want_res;
    fqp_result_t          pred_res;
    dir_row_t             dir_rows[$];

    int                   mismatches = 0;
    int                   idle_cycles = 0;
    int                   rand_sent = 0;
    int                   burst_left = 0;
    bit                   quiet = 1'b0;

    fastq_record_parser_top u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .byte_value   (byte_value),
        .stream_end   (stream_end),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_byte     (out_byte),
        .field_tag    (field_tag),
        .record_done  (record_done),
        .stream_done  (stream_done),
        .format_error (format_error),
        .seq_length   (seq_length)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic bit is_blank(input logic [7:0] b);
        return b == CH_SPACE || (b >= CH_TAB && b <= CH_CR);
    endfunction

    function automatic longint unsigned sat_inc(input longint unsigned v);
        return (v >= FQP_MAX_LEN) ? FQP_MAX_LEN : v + 1;
    endfunction

    function automatic logic [SEQ_LEN_W-1:0] shown_len();
        return (seq_cnt > 65535) ? 16'hFFFF : seq_cnt[SEQ_LEN_W-1:0];
    endfunction

    function automatic void parser_clear();
        ps = PS_WAIT_AT;
        seq_cnt = 0;
        qual_cnt = 0;
        err_flag = 1'b0;
    endfunction

    function automatic fqp_result_t parse_byte(input logic [7:0] b, input logic e);
        fqp_result_t r;
        r = '0;
        if (e || b == 8'h00 || b[7])
        begin
            r.stream_done = 1'b1;
            r.format_error = err_flag;
            r.seq_length = shown_len();
            parser_clear();
            return r;
        end
        case (ps)
            PS_HDR1:
                if (b == CH_NEWLINE)
                    ps = PS_SEQ;
                else
                begin
                    r.field_tag = TAG_H1;
                    r.out_byte = b;
                end
            PS_SEQ:
                if (!is_blank(b))
                begin
                    if (b == CH_PLUS)
                        ps = PS_HDR2;
                    else
                    begin
                        r.field_tag = TAG_SEQ;
                        r.out_byte = b;
                        seq_cnt = sat_inc(seq_cnt);
                    end
                end
            PS_HDR2:
                if (b == CH_NEWLINE)
                    ps = PS_QUAL;
                else
                begin
                    r.field_tag = TAG_H2;
                    r.out_byte = b;
                end
            PS_QUAL:
                if (!is_blank(b))
                begin
                    r.field_tag = TAG_QUAL;
                    r.out_byte = b;
                    if (qual_cnt + 1 >= seq_cnt)
                        r.record_done = 1'b1;
                    qual_cnt = sat_inc(qual_cnt);
                end
            default:
                if (!is_blank(b))
                begin
                    if (b == CH_AT)
                        ps = PS_HDR1;
                    else
                        err_flag = 1'b1;
                end
        endcase
        r.format_error = err_flag;
        r.seq_length = shown_len();
        if (r.record_done)
        begin
            ps = PS_WAIT_AT;
            seq_cnt = 0;
            qual_cnt = 0;
        end
        return r;
    endfunction

    // request tracking and result checking
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (in_valid && !in_stall)
            begin
                pred_res = parse_byte(byte_value, stream_end);
                parsed_bytes.push_back(req_typed ? req_res : pred_res);
            end
            if (out_valid && !out_stall)
            begin
                got_res.out_byte = out_byte;
                got_res.field_tag = fqp_tag_t'(field_tag);
                got_res.record_done = record_done;
                got_res.stream_done = stream_done;
                got_res.format_error = format_error;
                got_res.seq_length = seq_length;
                if (parsed_bytes.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: result with nothing pending: byte %h tag %0d", $realtime,
                                 out_byte, field_tag);
                end
                else
                begin
                    want_res = parsed_bytes.pop_front();
                    if (got_res !== want_res)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                        begin
                            $display("%0t: exp byte %h tag %0d done %b end %b err %b len %0d",
                                     $realtime, want_res.out_byte, want_res.field_tag,
                                     want_res.record_done, want_res.stream_done,
                                     want_res.format_error, want_res.seq_length);
                            $display("%0t: got byte %h tag %0d done %b end %b err %b len %0d",
                                     $realtime, got_res.out_byte, got_res.field_tag,
                                     got_res.record_done, got_res.stream_done,
                                     got_res.format_error, got_res.seq_length);
                        end
                    end
                end
            end
        end
    end

    // receiver stall pattern
    initial
    begin
        int pick;
        int len;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            pick = $urandom_range(0, 99);
            if (quiet || pick < 50)
            begin
                out_stall <= 1'b0;
                len = quiet ? 1 : $urandom_range(1, 20);
            end
            else if (pick < 85)
            begin
                out_stall <= 1'b1;
                len = $urandom_range(1, 3);
            end
            else if (pick < 95)
            begin
                out_stall <= 1'b1;
                len = $urandom_range(5, 40);
            end
            else
            begin
                out_stall <= 1'b0;
                len = $urandom_range(100, 400);
            end
            repeat (len) @(posedge clk);
        end
    end

    function automatic int pick_gap();
        int r;
        if (quiet)
            return 0;
        if (burst_left > 0)
        begin
            burst_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 95)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    task automatic send_req(input logic [7:0] b, input logic e, input bit typed = 1'b0,
                            input fqp_result_t res = '0);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        byte_value <= b;
        stream_end <= e;
        req_typed <= typed;
        req_res <= res;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (parsed_bytes.size() != 0)
            @(posedge clk);
    endtask

    function automatic dir_row_t mk_row(input logic [7:0] b, input logic e, input bit typed,
                                        input logic [7:0] ob, input fqp_tag_t tag,
                                        input logic rd, input logic sd, input logic fe,
                                        input logic [15:0] len);
        dir_row_t row;
        row.b = b;
        row.e = e;
        row.typed = typed;
        row.res.out_byte = ob;
        row.res.field_tag = tag;
        row.res.record_done = rd;
        row.res.stream_done = sd;
        row.res.format_error = fe;
        row.res.seq_length = len;
        return row;
    endfunction

    function automatic logic [7:0] blank_byte();
        int k;
        k = $urandom_range(0, 5);
        return (k == 5) ? CH_SPACE : 8'(9 + k);
    endfunction

    function automatic logic [7:0] text_byte(input bit no_blank, input bit no_plus);
        logic [7:0] b;
        do
            b = 8'($urandom_range(1, 127));
        while ((no_blank && is_blank(b)) || (no_plus && b == CH_PLUS));
        return b;
    endfunction

    function automatic logic [8:0] stop_item();
        int k;
        k = $urandom_range(0, 2);
        if (k == 0)
            return {1'b1, 8'($urandom_range(0, 255))};
        if (k == 1)
            return 9'h000;
        return {1'b0, 8'($urandom_range(128, 255))};
    endfunction

    task automatic send_record();
        logic [8:0] items[$];
        int kind;
        int n_seq;
        int n_qual;
        logic [7:0] b;
        kind = $urandom_range(0, 99);
        if ($urandom_range(0, 9) == 0)
            burst_left = 40;
        if (kind < 8)
        begin
            repeat ($urandom_range(1, 6))
                items.push_back({1'($urandom_range(0, 19) == 0), 8'($urandom_range(0, 255))});
        end
        else
        begin
            repeat ($urandom_range(0, 2))
                items.push_back({1'b0, blank_byte()});
            items.push_back({1'b0, CH_AT});
            repeat ($urandom_range(0, 12))
            begin
                do
                    b = text_byte(1'b0, 1'b0);
                while (b == CH_NEWLINE);
                items.push_back({1'b0, b});
            end
            items.push_back({1'b0, CH_NEWLINE});
            n_seq = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 24);
            repeat (n_seq)
            begin
                if ($urandom_range(0, 5) == 0)
                    items.push_back({1'b0, blank_byte()});
                items.push_back({1'b0, text_byte(1'b1, 1'b1)});
            end
            items.push_back({1'b0, CH_PLUS});
            repeat ($urandom_range(0, 6))
            begin
                do
                    b = text_byte(1'b0, 1'b0);
                while (b == CH_NEWLINE);
                items.push_back({1'b0, b});
            end
            items.push_back({1'b0, CH_NEWLINE});
            n_qual = (n_seq == 0) ? 1 : n_seq;
            repeat (n_qual)
            begin
                if ($urandom_range(0, 5) == 0)
                    items.push_back({1'b0, blank_byte()});
                items.push_back({1'b0, text_byte(1'b1, 1'b0)});
            end
            // broken record: cut short by an end of stream
            if (kind < 22)
            begin
                items = items[0:$urandom_range(0, items.size() - 1)];
                items.push_back(stop_item());
            end
        end
        foreach (items[i])
        begin
            send_req(items[i][7:0], items[i][8]);
            rand_sent++;
        end
    endtask

    // records back to back with no gaps; the receiver stops stalling once its current stall pattern runs out
    task automatic send_quiet_records();
        quiet = 1'b1;
        repeat (4) send_record();
        quiet = 1'b0;
    endtask

    initial
    begin
        parser_clear();
        dir_rows.push_back(mk_row("A",        1, 1, 8'h00,    TAG_SKIP, 0, 1, 0, 0));
        dir_rows.push_back(mk_row(8'hFF,      1, 1, 8'h00,    TAG_SKIP, 0, 1, 0, 0));
        dir_rows.push_back(mk_row(CH_SPACE,   0, 1, 8'h00,    TAG_SKIP, 0, 0, 0, 0));
        dir_rows.push_back(mk_row("x",        0, 1, 8'h00,    TAG_SKIP, 0, 0, 1, 0));
        dir_rows.push_back(mk_row(CH_TAB,     0, 1, 8'h00,    TAG_SKIP, 0, 0, 1, 0));
        dir_rows.push_back(mk_row(8'h00,      0, 1, 8'h00,    TAG_SKIP, 0, 1, 1, 0));
        dir_rows.push_back(mk_row(CH_AT,      0, 1, 8'h00,    TAG_SKIP, 0, 0, 0, 0));
        dir_rows.push_back(mk_row("r",        0, 1, "r",      TAG_H1,   0, 0, 0, 0));
        dir_rows.push_back(mk_row(CH_SPACE,   0, 1, CH_SPACE, TAG_H1,   0, 0, 0, 0));
        dir_rows.push_back(mk_row(CH_NEWLINE, 0, 1, 8'h00,    TAG_SKIP, 0, 0, 0, 0));
        dir_rows.push_back(mk_row("A",        0, 0, 8'h00,    TAG_SKIP, 0, 0, 0, 0));
        dir_rows.push_back(mk_row(CH_CR,      0, 0, 8'h00,    TAG_SKIP, 0, 0, 0, 0));
        dir_rows.push_back(mk_row(CH_NEWLINE, 0, 0, 8'h00,    TAG_SKIP, 0, 0, 0, 0));
        dir_rows.push_back(mk_row("C",        0, 0, 8'h00,    TAG_SKIP, 0, 0, 0, 0));
        dir_rows.push_back(mk_row(CH_PLUS,    0, 0, 8'h00,    TAG_SKIP, 0, 0, 0, 0));
        dir_rows.push_back(mk_row("h",        0, 0, 8'h00,    TAG_SKIP, 0, 0, 0, 0));
        dir_rows.push_back(mk_row(CH_NEWLINE, 0, 0, 8'h00,    TAG_SKIP, 0, 0, 0, 0));
        dir_rows.push_back(mk_row("I",        0, 0, 8'h00,    TAG_SKIP, 0, 0, 0, 0));
        dir_rows.push_back(mk_row(CH_SPACE,   0, 0, 8'h00,    TAG_SKIP, 0, 0, 0, 0));
        dir_rows.push_back(mk_row("~",        0, 0, 8'h00,    TAG_SKIP, 0, 0, 0, 0));
        // empty sequence closes on the first quality byte
        dir_rows.push_back(mk_row(CH_AT,      0, 0, 8'h00,    TAG_SKIP, 0, 0, 0, 0));
        dir_rows.push_back(mk_row(CH_NEWLINE, 0, 0, 8'h00,    TAG_SKIP, 0, 0, 0, 0));
        dir_rows.push_back(mk_row(CH_PLUS,    0, 0, 8'h00,    TAG_SKIP, 0, 0, 0, 0));
        dir_rows.push_back(mk_row(CH_NEWLINE, 0, 0, 8'h00,    TAG_SKIP, 0, 0, 0, 0));
        dir_rows.push_back(mk_row("!",        0, 0, 8'h00,    TAG_SKIP, 0, 0, 0, 0));
        dir_rows.push_back(mk_row(CH_AT,      0, 0, 8'h00,    TAG_SKIP, 0, 0, 0, 0));
        dir_rows.push_back(mk_row(8'h80,      0, 1, 8'h00,    TAG_SKIP, 0, 1, 0, 0));

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
            send_req(dir_rows[i].b, dir_rows[i].e, dir_rows[i].typed, dir_rows[i].res);
        drain_results();

        while (rand_sent < RAND_ITEMS / 2)
            send_record();
        drain_results();
        send_quiet_records();
        while (rand_sent < RAND_ITEMS)
            send_record();

        drain_results();
        repeat (10) @(posedge clk);
        mismatches += parsed_bytes.size();
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        while (idle_cycles < IDLE_LIMIT)
            @(posedge clk);
        $display("%0t: no request accepted for %0d cycles", $realtime, IDLE_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
